@@ hw/rtl/deq_pkg.sv @@
// deq_pkg: shared types, constants and ring index helpers for the double-ended queue
// used by double_ended_queue; no dependencies
package deq_pkg;

    // ring geometry
    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int DATA_W = 32;

    localparam logic signed [DATA_W-1:0] NEG_ONE = -32'sd1;

    // operation codes
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } t_state;

    // input beat
    typedef struct packed {
        t_op                       operation;
        logic signed [DATA_W-1:0]  push_value;
    } t_in;

    // result beat
    typedef struct packed {
        logic signed [DATA_W-1:0]  popped_value;
        logic                      pop_done;
        logic                      push_dropped;
        logic [CNT_W-1:0]          entry_count;
        logic                      is_vacant;
        logic signed [DATA_W-1:0]  front_value;
        logic signed [DATA_W-1:0]  back_value;
    } t_out;

    // ring position one step forward
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

    // ring position one step back
    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = idx - IDX_W'(1);
        end
        return res;
    endfunction

    // fold a sum below twice the depth back into the ring
    function automatic logic [IDX_W-1:0] idx_wrap(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] res;
        if (sum >= SUM_W'(DEPTH)) begin
            res = sum - SUM_W'(DEPTH);
        end else begin
            res = sum;
        end
        return res[IDX_W-1:0];
    endfunction

endpackage

@@ hw/rtl/deq_ram.sv @@
// deq_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/double_ended_queue.sv @@
// double_ended_queue: ring-buffer deque of signed 32-bit values with push/pop at both ends
// depends on deq_pkg and deq_ram
//
// Each input beat is a push or pop at the front or back and yields exactly one result beat
// carrying the popped value, flags, the count and the front and back values afterwards.
// Entries live in one DEPTH-deep ram; the current front and back values are also held in
// registers so most operations finish without a ram read. Pushes, pops from an empty queue
// and pops that leave the queue empty finish in ST_IDLE; a pop that leaves entries behind
// also passes through ST_FETCH, because the new front (or back) has to come from the ram
// through its registered read port. A full queue drops a push and flags it. The result
// sits in an output register; a new beat is taken only in ST_IDLE while that register is
// empty or its result leaves in the same cycle, so a stalled result holds the input off.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_state r_state, n_state;
    logic [IDX_W-1:0]         r_head, n_head;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [DATA_W-1:0] r_front, n_front;
    logic signed [DATA_W-1:0] r_back, n_back;
    logic                     r_side_front, n_side_front;
    logic                     r_out_valid, n_out_valid;
    t_out                     r_out, n_out;

    logic                     w_accept;
    logic                     w_fetch;
    logic                     w_we;
    logic [IDX_W-1:0]         w_waddr;
    logic [IDX_W-1:0]         w_raddr;
    logic [DATA_W-1:0]        w_rdata;
    logic [SUM_W-1:0]         w_sum;
    logic                     w_full;
    logic                     w_empty;

    // entry storage
    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.push_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // input handshake: free output slot (or one leaving now) and no fetch in flight
    assign o_in_stall  = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_sum   = {1'b0, r_head} + SUM_W'(r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_fetch) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_front      = r_front;
        n_back       = r_back;
        n_side_front = r_side_front;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        w_fetch      = 1'b0;
        w_we         = 1'b0;
        w_waddr      = idx_wrap(w_sum);
        w_raddr      = idx_inc(r_head);

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out.popped_value = NEG_ONE;
                    n_out.pop_done     = 1'b0;
                    n_out.push_dropped = 1'b0;
                    unique case (i_in.operation) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (w_full) begin
                                n_out.push_dropped = 1'b1;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (i_in.operation == OP_PUSH_FRONT) begin
                                    n_head  = idx_dec(r_head);
                                    w_waddr = idx_dec(r_head);
                                    n_front = i_in.push_value;
                                    if (w_empty) begin
                                        n_back = i_in.push_value;
                                    end
                                end else begin
                                    n_back = i_in.push_value;
                                    if (w_empty) begin
                                        n_front = i_in.push_value;
                                    end
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (!w_empty) begin
                                n_count        = r_count - CNT_W'(1);
                                n_out.pop_done = 1'b1;
                                n_side_front   = (i_in.operation == OP_POP_FRONT);
                                if (i_in.operation == OP_POP_FRONT) begin
                                    n_out.popped_value = r_front;
                                    n_head             = idx_inc(r_head);
                                    w_raddr            = idx_inc(r_head);
                                end else begin
                                    n_out.popped_value = r_back;
                                    w_raddr            = idx_wrap(w_sum - SUM_W'(2));
                                end
                                // any entry left over means a new end must come from ram
                                w_fetch = (r_count != CNT_W'(1));
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.entry_count = n_count;
                    n_out.is_vacant   = (n_count == '0);
                    n_out.front_value = (n_count == '0) ? NEG_ONE : n_front;
                    n_out.back_value  = (n_count == '0) ? NEG_ONE : n_back;
                    n_out_valid       = !w_fetch;
                end
            end
            ST_FETCH: begin
                // ram data is the new front or back entry
                if (r_side_front) begin
                    n_front           = w_rdata;
                    n_out.front_value = w_rdata;
                end else begin
                    n_back            = w_rdata;
                    n_out.back_value  = w_rdata;
                end
                n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_front      <= n_front;
        r_back       <= n_back;
        r_side_front <= n_side_front;
        r_out        <= n_out;
    end

endmodule
